@@ sv/itad_pkg.sv @@
// itad_pkg: types, codes and character constants shared by the integer to
// ASCII digit converter. No dependencies.
`timescale 1ns / 1ps

package itad_pkg;

  // radix codes carried in the mode field
  localparam logic [1:0] MODE_DEC = 2'd0;
  localparam logic [1:0] MODE_HEX = 2'd1;
  localparam logic [1:0] MODE_BIN = 2'd2;
  // carries no radix; the item is taken and nothing is emitted
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int VALUE_W  = 32;
  localparam int CHAR_W   = 7;
  localparam int BCD_DIGS = 10;
  localparam int BCD_W    = 4 * BCD_DIGS;
  localparam int CNT_W    = 5;

  // counter preload values
  localparam logic [CNT_W-1:0] CNT_BITS = CNT_W'(VALUE_W - 1);
  localparam logic [CNT_W-1:0] CNT_HEX  = CNT_W'(VALUE_W / 4 - 1);
  localparam logic [CNT_W-1:0] CNT_DEC  = CNT_W'(BCD_DIGS - 1);

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_ONE  = 7'h31;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_B    = 7'h62;

  typedef struct packed {
    logic [1:0]         mode;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SKIP,
    ST_DEC,
    ST_HEX,
    ST_PRE0,
    ST_PREB,
    ST_BIN
  } state_t;

  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_B,
    SEL_BIT,
    SEL_HEX,
    SEL_DEC
  } char_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_SET,
    CNT_DECR
  } cnt_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             dabble;
    logic             bcd_shl;
    logic             v_shl1;
    logic             v_shl4;
    cnt_op_t          cnt_op;
    logic [CNT_W-1:0] cnt_val;
    logic             emit;
    logic             last;
    char_sel_t        char_sel;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic cnt_zero;
    logic top_zero;
  } status_t;

endpackage

@@ sv/itad_dpath.sv @@
// itad_dpath: value shifter, binary to BCD register, step counter and the
// registered result stage. Depends on itad_pkg.
`timescale 1ns / 1ps

module itad_dpath import itad_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  item_t   operand,
  input  ctl_t    ctl,
  output status_t status,
  output logic    strobe,
  output result_t result
);

  logic [VALUE_W-1:0] v;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt;
  logic [3:0]         nib;
  logic [CHAR_W-1:0]  char_next;

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // value and BCD registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v   <= operand.value;
      bcd <= '0;
    end else begin
      if (ctl.dabble) begin
        bcd <= {bcd_adj[BCD_W-2:0], v[VALUE_W-1]};
        v   <= {v[VALUE_W-2:0], 1'b0};
      end
      if (ctl.bcd_shl) bcd <= {bcd[BCD_W-5:0], 4'd0};
      if (ctl.v_shl1)  v   <= {v[VALUE_W-2:0], 1'b0};
      if (ctl.v_shl4)  v   <= {v[VALUE_W-5:0], 4'd0};
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (ctl.cnt_op)
        CNT_SET:  cnt <= ctl.cnt_val;
        CNT_DECR: cnt <= cnt - 1'b1;
        default:  cnt <= cnt;
      endcase
    end
  end

  assign status.cnt_zero = (cnt == '0);
  assign status.top_zero = (bcd[BCD_W-1 -: 4] == 4'd0);

  // character select
  assign nib = v[VALUE_W-1 -: 4];
  always_comb begin
    case (ctl.char_sel)
      SEL_ZERO: char_next = CHAR_ZERO;
      SEL_B:    char_next = CHAR_B;
      SEL_BIT:  char_next = v[VALUE_W-1] ? CHAR_ONE : CHAR_ZERO;
      SEL_HEX:  char_next = (nib > 4'd9) ? {3'd0, nib} + (CHAR_A - 7'd10)
                                         : {3'd0, nib} + CHAR_ZERO;
      SEL_DEC:  char_next = {3'd0, bcd[BCD_W-1 -: 4]} + CHAR_ZERO;
      default:  char_next = CHAR_ZERO;
    endcase
  end

  // result register; strobe marks each emitted character
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      result.character <= char_next;
      result.last      <= ctl.last;
    end
  end

endmodule

@@ sv/itad_ctrl.sv @@
// itad_ctrl: sequencing state machine for the converter; issues datapath
// commands from the mode and datapath status. Depends on itad_pkg.
`timescale 1ns / 1ps

module itad_ctrl import itad_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   operand,
  input  status_t status,
  output logic    busy,
  output ctl_t    ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.cnt_op   = CNT_HOLD;
    ctl.char_sel = SEL_ZERO;
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          ctl.cnt_op = CNT_SET;
          case (operand.mode)
            MODE_DEC: begin
              ctl.cnt_val = CNT_BITS;
              state_next  = ST_DABBLE;
            end
            MODE_HEX: begin
              ctl.cnt_val = CNT_HEX;
              state_next  = ST_HEX;
            end
            MODE_BIN: begin
              ctl.cnt_val = CNT_BITS;
              state_next  = ST_PRE0;
            end
            default: begin
              // unused code: item dropped, nothing emitted
              ctl.cnt_op = CNT_HOLD;
            end
          endcase
        end
      end
      // one shift-add-3 step per value bit
      ST_DABBLE: begin
        ctl.dabble = 1'b1;
        if (status.cnt_zero) begin
          ctl.cnt_op  = CNT_SET;
          ctl.cnt_val = CNT_DEC;
          state_next  = ST_SKIP;
        end else begin
          ctl.cnt_op = CNT_DECR;
        end
      end
      // drop leading zero digits, keep at least one
      ST_SKIP: begin
        ctl.bcd_shl = 1'b1;
        ctl.cnt_op  = CNT_DECR;
        if (!(status.top_zero && !status.cnt_zero)) begin
          ctl.emit     = 1'b1;
          ctl.char_sel = SEL_DEC;
          ctl.last     = status.cnt_zero;
          state_next   = status.cnt_zero ? ST_IDLE : ST_DEC;
        end
      end
      ST_DEC: begin
        ctl.emit     = 1'b1;
        ctl.char_sel = SEL_DEC;
        ctl.last     = status.cnt_zero;
        ctl.bcd_shl  = 1'b1;
        ctl.cnt_op   = CNT_DECR;
        if (status.cnt_zero) state_next = ST_IDLE;
      end
      ST_HEX: begin
        ctl.emit     = 1'b1;
        ctl.char_sel = SEL_HEX;
        ctl.last     = status.cnt_zero;
        ctl.v_shl4   = 1'b1;
        ctl.cnt_op   = CNT_DECR;
        if (status.cnt_zero) state_next = ST_IDLE;
      end
      ST_PRE0: begin
        ctl.emit     = 1'b1;
        ctl.char_sel = SEL_ZERO;
        state_next   = ST_PREB;
      end
      ST_PREB: begin
        ctl.emit     = 1'b1;
        ctl.char_sel = SEL_B;
        state_next   = ST_BIN;
      end
      ST_BIN: begin
        ctl.emit     = 1'b1;
        ctl.char_sel = SEL_BIT;
        ctl.last     = status.cnt_zero;
        ctl.v_shl1   = 1'b1;
        ctl.cnt_op   = CNT_DECR;
        if (status.cnt_zero) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ sv/integer_to_ascii_digits.sv @@
// integer_to_ascii_digits: top level of the 32-bit integer to ASCII converter.
// Depends on itad_pkg, itad_ctrl and itad_dpath.
//
//   channel   signals                        handshake
//   -------   ----------------------------   ------------------------------
//   item in   operand.mode, operand.value    taken when start && !busy
//   item out  result.character, result.last each marked by strobe
//
// Hex: 8 characters. Binary: 34 characters. Decimal: one shift-add-3
// conversion step per value bit, then a pass over the 10 BCD digits that
// skips leading zero digits and issues the rest one per cycle.
// The counter-driven controller handles one item at a time; busy stays high
// until the final character is issued. Mode 3 is taken and produces nothing.
// Synchronous reset returns to idle with no strobe; the receiver cannot stall.
`timescale 1ns / 1ps

module integer_to_ascii_digits import itad_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   operand,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  ctl_t    ctl;
  status_t status;

  itad_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .operand (operand),
    .status  (status),
    .busy    (busy),
    .ctl     (ctl)
  );

  itad_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .ctl     (ctl),
    .status  (status),
    .strobe  (strobe),
    .result  (result)
  );

  // a character only follows a busy cycle
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("strobe without a busy cycle before it");

  // final character leaves a gap before the next item's output
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !strobe)
    else $error("strobe right after a last character");

  // an unused mode is dropped at once
  a_unused_mode: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operand.mode == MODE_UNUSED) |=> !busy)
    else $error("unused mode started a conversion");

endmodule

@@ dv/tb_integer_to_ascii_digits.sv @@
// tb_integer_to_ascii_digits: self-checking testbench for the integer to ASCII
// digit converter. Depends on itad_pkg and integer_to_ascii_digits.
// Predicts each number's character stream and checks it character by character.
`timescale 1ns / 1ps

module tb_integer_to_ascii_digits;
  import itad_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 64;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   operand = '0;
  logic    busy;
  logic    strobe;
  result_t result;

  result_t expected_chars[$];
  int      err_count = 0;
  bit      gaps_on = 1'b1;

  integer_to_ascii_digits dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .operand (operand),
    .busy    (busy),
    .strobe  (strobe),
    .result  (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("[integer_to_ascii_digits] ERROR");
    $finish;
  end

  function automatic void report_mismatch(input string what, input result_t want,
                                          input result_t got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s: expected char %h last %b, got char %h last %b",
               $realtime, what, want.character, want.last, got.character, got.last);
  endfunction

  function automatic void push_char(input logic [CHAR_W-1:0] c, input logic is_last);
    result_t r;
    r.character = c;
    r.last      = is_last;
    expected_chars.push_back(r);
  endfunction

  // expected text of one number, most significant character first
  function automatic void predict_text(input item_t it);
    logic [3:0]  digs[BCD_DIGS];
    logic [31:0] v;
    logic [3:0]  nib;
    int          n;
    case (it.mode)
      MODE_DEC: begin
        v = it.value;
        n = 0;
        do begin
          digs[n] = 4'(v % 10);
          v = v / 10;
          n++;
        end while (v != 0);
        for (int i = n - 1; i >= 0; i--)
          push_char(CHAR_ZERO + CHAR_W'(digs[i]), i == 0);
      end
      MODE_HEX: begin
        for (int s = 7; s >= 0; s--) begin
          nib = it.value[4*s +: 4];
          if (nib > 4'd9)
            push_char(CHAR_A + CHAR_W'(nib - 4'd10), s == 0);
          else
            push_char(CHAR_ZERO + CHAR_W'(nib), s == 0);
        end
      end
      MODE_BIN: begin
        push_char(CHAR_ZERO, 1'b0);
        push_char(CHAR_B, 1'b0);
        for (int b = VALUE_W - 1; b >= 0; b--)
          push_char(it.value[b] ? CHAR_ONE : CHAR_ZERO, b == 0);
      end
      default: ;
    endcase
  endfunction

  // idle time before an item: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one item and hold it until the block takes it
  task automatic send_item(input logic [1:0] mode, input logic [31:0] value);
    item_t it;
    int    gap;
    it.mode  = mode;
    it.value = value;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    operand <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_text(it);
  endtask

  // each strobed character against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", '0, result);
      end else begin
        want = expected_chars.pop_front();
        if (want.character !== result.character)
          report_mismatch("character mismatch", want, result);
        else if (want.last !== result.last)
          report_mismatch("last flag mismatch", want, result);
      end
    end
  end

  // digit counts, zero, all ones and carry boundaries
  task automatic test_decimal_edges();
    send_item(MODE_DEC, 32'd0);
    send_item(MODE_DEC, 32'd1);
    send_item(MODE_DEC, 32'd9);
    send_item(MODE_DEC, 32'd10);
    send_item(MODE_DEC, 32'd999_999_999);
    send_item(MODE_DEC, 32'd1_000_000_000);
    send_item(MODE_DEC, 32'hFFFF_FFFF);
  endtask

  task automatic test_hex_edges();
    send_item(MODE_HEX, 32'h0000_0000);
    send_item(MODE_HEX, 32'hFFFF_FFFF);
    send_item(MODE_HEX, 32'h0123_ABCD);
    send_item(MODE_HEX, 32'h9A5F_E06B);
  endtask

  task automatic test_binary_edges();
    send_item(MODE_BIN, 32'h0000_0000);
    send_item(MODE_BIN, 32'hFFFF_FFFF);
    send_item(MODE_BIN, 32'h8000_0001);
    send_item(MODE_BIN, 32'h5555_AAAA);
  endtask

  // unused mode emits nothing and must not disturb the next number
  task automatic test_unused_mode();
    send_item(MODE_UNUSED, 32'h0000_0000);
    send_item(MODE_UNUSED, 32'hFFFF_FFFF);
    send_item(MODE_DEC, 32'd4_096);
    send_item(MODE_UNUSED, 32'h1234_5678);
    send_item(MODE_HEX, 32'hDEAD_BEEF);
  endtask

  // random radix and value shapes; unused-mode items do not count
  task automatic test_random_mix(input int count);
    logic [1:0]  mode;
    logic [31:0] value;
    int          sent;
    int          r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      mode = (r < 45) ? MODE_DEC : (r < 70) ? MODE_HEX : (r < 95) ? MODE_BIN : MODE_UNUSED;
      r = $urandom_range(0, 9);
      if (r < 4) begin
        value = $urandom();
      end else if (r < 6) begin
        value = $urandom_range(0, 999);
      end else if (r < 8) begin
        // power of ten, or just below it
        value = 32'd1;
        repeat ($urandom_range(0, 9)) value = value * 10;
        if ($urandom_range(0, 1)) value = value - 1;
      end else begin
        value = 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1)) value = ~value;
      end
      send_item(mode, value);
      if (mode != MODE_UNUSED) sent++;
      // switch idling off for stretches
      if ($urandom_range(0, 19) == 0) gaps_on = ~gaps_on;
    end
    gaps_on = 1'b1;
  endtask

  // items offered with no idle gap, each as soon as the block is free
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    for (int i = 0; i < 24; i++)
      send_item(2'(i % 3), $urandom());
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_decimal_edges();
    test_hex_edges();
    test_binary_edges();
    test_unused_mode();
    test_random_mix(160);
    test_back_to_back();

    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_chars.size() != 0) err_count++;
    if (err_count == 0)
      $display("[integer_to_ascii_digits] OK");
    else
      $display("[integer_to_ascii_digits] ERROR");
    $finish;
  end

endmodule
